FILE: rtl/btm_pkg.sv
// shared types and constants for the binary turing machine step block
// no dependencies
package btm_pkg;

  localparam int RULE_ENTRIES = 16;
  localparam int TAPE_CELLS   = 1024;
  localparam int STATE_BITS   = 8;

  localparam int STATE_W  = STATE_BITS;
  localparam int RULE_AW  = $clog2(RULE_ENTRIES);
  localparam int RCNT_W   = $clog2(RULE_ENTRIES + 1);
  localparam int TAPE_AW  = $clog2(TAPE_CELLS);

  localparam int REQ_W    = 3;
  localparam int RIDX_W   = 4;
  localparam int FSTATE_W = 8;
  localparam int ADDR_W   = 10;
  localparam int MOVE_W   = 2;
  localparam int ERR_W    = 2;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 10;
  localparam int RCFG_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_READ  = 3'd2,
    REQ_START = 3'd3,
    REQ_STEP  = 3'd4
  } req_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_RULE  = 2'd1,
    ERR_OFF_TAPE = 2'd2,
    ERR_HALTED   = 2'd3
  } err_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_START_STATE = 2'd0,
    CFG_HEAD_START  = 2'd1,
    CFG_RULE_COUNT  = 2'd2
  } cfg_e;

  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'b01;
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'b11;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic               rd;
    logic               wr;
    logic [MOVE_W-1:0]  move;
    logic [STATE_W-1:0] next;
  } rule_t;

  typedef struct packed {
    logic               en;
    logic [TAPE_AW-1:0] addr;
    logic               data;
  } tape_wr_t;

  typedef struct packed {
    logic               en;
    logic [RULE_AW-1:0] addr;
    rule_t              data;
  } rule_wr_t;

endpackage

FILE: rtl/btm_tape_mem.sv
// tape cell memory, one write and one registered read port
// depends on btm_pkg
module btm_tape_mem import btm_pkg::*; (
  input  logic               clk_i,
  input  tape_wr_t           wr_i,
  input  logic [TAPE_AW-1:0] raddr_i,
  output logic               rdata_o
);

  logic mem [TAPE_CELLS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/btm_rule_mem.sv
// rule table memory, one write and one registered read port
// depends on btm_pkg
module btm_rule_mem import btm_pkg::*; (
  input  logic               clk_i,
  input  rule_wr_t           wr_i,
  input  logic [RULE_AW-1:0] raddr_i,
  output rule_t              rdata_o
);

  rule_t mem [RULE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/binary_turing_machine_step.sv
// binary turing machine step block: request sequencer, machine registers, output register
// depends on btm_pkg, btm_tape_mem and btm_rule_mem
//
// usage
// - request channel (in_valid_i / in_ready_o) carries one request: load rule, write cell,
//   read cell, start or step; every request gives exactly one result on the result
//   channel (out_valid_o / out_ready_i)
// - configuration channel (cfg_valid_i / cfg_ready_o) is always ready; index 0 start
//   state, 1 head start cell, 2 rule count; other indexes are ignored
// - one request is worked on at a time; load rule, write cell, start and unknown requests
//   go from acceptance straight to the done state, read cell passes a cell read state first,
//   and a step passes a tape wait state and a scan state that reads up to 16 rule entries,
//   one per cycle through the rule memory's single read port, until the first match
// - a step that finds the machine halted goes straight to the done state with error halted
// - after reset the tape memory is cleared one cell a cycle while no request is taken; the
//   machine comes up halted in state 0 with the head on cell 0
// - a finished result waits in the output register while the receiver stalls; the next
//   request is taken meanwhile and its result is held back until the register is free
module binary_turing_machine_step import btm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_IW-1:0]   cfg_index_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [RIDX_W-1:0]   rule_index_i,
  input  logic [FSTATE_W-1:0] rule_state_i,
  input  logic                rule_read_symbol_i,
  input  logic                rule_write_symbol_i,
  input  logic [MOVE_W-1:0]   rule_move_i,
  input  logic [FSTATE_W-1:0] rule_next_state_i,
  input  logic [ADDR_W-1:0]   cell_address_i,
  input  logic                cell_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FSTATE_W-1:0] current_state_o,
  output logic [ADDR_W-1:0]   head_position_o,
  output logic                symbol_out_o,
  output logic                halted_o,
  output logic [ERR_W-1:0]    error_code_o,
  output logic [RIDX_W-1:0]   fired_rule_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_TAPE_WAIT,
    ST_SCAN,
    ST_DONE
  } fsm_e;

  fsm_e                st_q;
  logic [TAPE_AW-1:0]  clr_q;
  logic [STATE_W-1:0]  mstate_q;
  logic [TAPE_AW-1:0]  head_q;
  logic                halt_q;
  logic [FSTATE_W-1:0] start_state_q;
  logic [ADDR_W-1:0]   head_start_q;
  logic [RCFG_W-1:0]   rule_count_q;
  logic [RULE_AW-1:0]  scan_idx_q;
  logic                cur_q;
  logic                addr_ok_q;
  logic                res_sym_q;
  err_e                res_err_q;
  logic [RULE_AW-1:0]  res_fired_q;

  logic                out_valid_q;
  logic [FSTATE_W-1:0] out_state_q;
  logic [ADDR_W-1:0]   out_head_q;
  logic                out_sym_q;
  logic                out_halt_q;
  logic [ERR_W-1:0]    out_err_q;
  logic [RIDX_W-1:0]   out_fired_q;

  tape_wr_t            tape_wr;
  logic [TAPE_AW-1:0]  tape_raddr;
  logic                tape_rdata;
  rule_wr_t            rule_wr;
  logic [RULE_AW-1:0]  rule_raddr;
  rule_t               rule_rdata;

  logic                in_acc;
  logic                cell_ok;
  logic [RCNT_W-1:0]   n_cnt;
  logic [RCNT_W-1:0]   scan_next;
  logic                rule_hit;
  logic                scan_last;
  logic [TAPE_AW-1:0]  fire_head;
  logic                fire_off;
  logic                out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cell_ok     = (int'(cell_address_i) < TAPE_CELLS);

  assign n_cnt     = (int'(rule_count_q) > RULE_ENTRIES) ? RCNT_W'(RULE_ENTRIES)
                                                         : RCNT_W'(rule_count_q);
  assign scan_next = RCNT_W'(scan_idx_q) + RCNT_W'(1);
  assign rule_hit  = (rule_rdata.state == mstate_q) && (rule_rdata.rd == cur_q);
  assign scan_last = (scan_next == n_cnt);

  always_comb begin
    fire_head = head_q;
    fire_off  = 1'b0;
    case (rule_rdata.move)
      MOVE_RIGHT: begin
        if (head_q == TAPE_AW'(TAPE_CELLS - 1)) fire_off = 1'b1;
        else fire_head = head_q + TAPE_AW'(1);
      end
      MOVE_LEFT: begin
        if (head_q == '0) fire_off = 1'b1;
        else fire_head = head_q - TAPE_AW'(1);
      end
      default: begin
        fire_head = head_q;
      end
    endcase
  end

  // memory ports
  always_comb begin
    tape_wr      = '0;
    rule_wr      = '0;
    tape_raddr   = head_q;
    rule_raddr   = '0;
    if (st_q == ST_CLEAR) begin
      tape_wr.en   = 1'b1;
      tape_wr.addr = clr_q;
      tape_wr.data = 1'b0;
    end else if (in_acc && req_type_i == REQ_WRITE && cell_ok) begin
      tape_wr.en   = 1'b1;
      tape_wr.addr = TAPE_AW'(cell_address_i);
      tape_wr.data = cell_value_i;
    end else if (st_q == ST_SCAN && rule_hit) begin
      tape_wr.en   = 1'b1;
      tape_wr.addr = head_q;
      tape_wr.data = rule_rdata.wr;
    end
    if (in_acc && req_type_i == REQ_READ) begin
      tape_raddr = TAPE_AW'(cell_address_i);
    end
    if (in_acc && req_type_i == REQ_LOAD && int'(rule_index_i) < RULE_ENTRIES) begin
      rule_wr.en         = 1'b1;
      rule_wr.addr       = RULE_AW'(rule_index_i);
      rule_wr.data.state = STATE_W'(rule_state_i);
      rule_wr.data.rd    = rule_read_symbol_i;
      rule_wr.data.wr    = rule_write_symbol_i;
      rule_wr.data.move  = rule_move_i;
      rule_wr.data.next  = STATE_W'(rule_next_state_i);
    end
    if (st_q == ST_SCAN) begin
      rule_raddr = RULE_AW'(scan_next);
    end
  end

  btm_tape_mem u_tape (
    .clk_i   (clk_i),
    .wr_i    (tape_wr),
    .raddr_i (tape_raddr),
    .rdata_o (tape_rdata)
  );

  btm_rule_mem u_rule (
    .clk_i   (clk_i),
    .wr_i    (rule_wr),
    .raddr_i (rule_raddr),
    .rdata_o (rule_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_CLEAR;
      clr_q         <= '0;
      mstate_q      <= '0;
      head_q        <= '0;
      halt_q        <= 1'b1;
      start_state_q <= FSTATE_W'(1);
      head_start_q  <= ADDR_W'(512);
      rule_count_q  <= '0;
      scan_idx_q    <= '0;
      cur_q         <= 1'b0;
      addr_ok_q     <= 1'b0;
      res_sym_q     <= 1'b0;
      res_err_q     <= ERR_NONE;
      res_fired_q   <= '0;
      out_valid_q   <= 1'b0;
      out_state_q   <= '0;
      out_head_q    <= '0;
      out_sym_q     <= 1'b0;
      out_halt_q    <= 1'b0;
      out_err_q     <= '0;
      out_fired_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_START_STATE: start_state_q <= FSTATE_W'(cfg_data_i);
          CFG_HEAD_START:  head_start_q  <= cfg_data_i;
          CFG_RULE_COUNT:  rule_count_q  <= RCFG_W'(cfg_data_i);
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_ready_i && st_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_CLEAR: begin
          clr_q <= clr_q + TAPE_AW'(1);
          if (clr_q == TAPE_AW'(TAPE_CELLS - 1)) st_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            res_sym_q   <= 1'b0;
            res_err_q   <= (req_type_i == REQ_STEP && halt_q) ? ERR_HALTED : ERR_NONE;
            res_fired_q <= '0;
            addr_ok_q   <= cell_ok;
            case (req_e'(req_type_i))
              REQ_READ: begin
                st_q <= ST_CELL_RD;
              end
              REQ_START: begin
                mstate_q <= STATE_W'(start_state_q);
                head_q   <= (int'(head_start_q) >= TAPE_CELLS) ? TAPE_AW'(TAPE_CELLS - 1)
                                                                : TAPE_AW'(head_start_q);
                halt_q   <= (STATE_W'(start_state_q) == '0);
                st_q     <= ST_DONE;
              end
              REQ_STEP: begin
                st_q <= halt_q ? ST_DONE : ST_TAPE_WAIT;
              end
              default: begin
                st_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_CELL_RD: begin
          res_sym_q <= tape_rdata & addr_ok_q;
          st_q      <= ST_DONE;
        end
        ST_TAPE_WAIT: begin
          cur_q      <= tape_rdata;
          scan_idx_q <= '0;
          if (n_cnt == '0) begin
            halt_q    <= 1'b1;
            res_err_q <= ERR_NO_RULE;
            st_q      <= ST_DONE;
          end else begin
            st_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rule_hit) begin
            res_sym_q   <= rule_rdata.wr;
            res_fired_q <= scan_idx_q;
            mstate_q    <= rule_rdata.next;
            head_q      <= fire_head;
            res_err_q   <= fire_off ? ERR_OFF_TAPE : ERR_NONE;
            halt_q      <= fire_off || (rule_rdata.next == '0);
            st_q        <= ST_DONE;
          end else if (scan_last) begin
            halt_q    <= 1'b1;
            res_err_q <= ERR_NO_RULE;
            st_q      <= ST_DONE;
          end else begin
            scan_idx_q <= RULE_AW'(scan_next);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_state_q <= FSTATE_W'(mstate_q);
            out_head_q  <= ADDR_W'(head_q);
            out_sym_q   <= res_sym_q;
            out_halt_q  <= halt_q;
            out_err_q   <= res_err_q;
            out_fired_q <= RIDX_W'(res_fired_q);
            st_q        <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_state_o = out_state_q;
  assign head_position_o = out_head_q;
  assign symbol_out_o    = out_sym_q;
  assign halted_o        = out_halt_q;
  assign error_code_o    = out_err_q;
  assign fired_rule_o    = out_fired_q;

endmodule
